FILE: design/nfrc_pkg.sv
// nfrc_pkg: shared types, constants and saturating fixed-point helpers
// for the newton fractal root classifier
// no dependencies
package nfrc_pkg;

	// defaults for the top-level parameters
	localparam int DEF_GRID_SIZE     = 64;
	localparam int DEF_FRACTION_BITS = 24;

	// tolerance register carries 24 fraction bits
	localparam int TOL_FRACTION = 24;
	localparam int TOL_W        = 25;
	localparam int ITER_W       = 8;
	localparam int CFG_DATA_W   = 25;

	// configuration register indexes
	localparam logic CFG_TOLERANCE  = 1'b0;
	localparam logic CFG_ITER_COUNT = 1'b1;

	// result codes
	localparam int         CODE_W    = 3;
	localparam int         NUM_ROOTS = 5;
	localparam logic [2:0] ROOT_NONE = 3'd0;

	// divider ring: cells in the ring and quotient bits per division
	localparam int DIV_CELLS = 8;
	localparam int DIV_STEPS = 128;

	typedef logic signed [63:0] fx_t;
	typedef logic [127:0] wide_t;

	localparam fx_t FX_MAX = {1'b0, {63{1'b1}}};
	localparam fx_t FX_MIN = {1'b1, {63{1'b0}}};

	typedef struct packed {
		logic  neg;
		wide_t m;
	} sgnwide_t;

	// one division lane: partial remainder and numerator/quotient shifter
	typedef struct packed {
		logic [63:0] rem;
		wide_t       nq;
	} div_lane_t;

	// data passed from one divider cell to the next
	typedef struct packed {
		logic [63:0] den;
		div_lane_t   re;
		div_lane_t   im;
	} div_data_t;

	// saturating add
	function automatic fx_t sat_add(fx_t a, fx_t b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? FX_MIN : FX_MAX;
		return s[63:0];
	endfunction

	// saturating subtract
	function automatic fx_t sat_sub(fx_t a, fx_t b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? FX_MIN : FX_MAX;
		return s[63:0];
	endfunction

	// magnitude, most negative value maps to 2^63
	function automatic logic [63:0] mag64(fx_t v);
		return v[63] ? (~$unsigned(v)) + 64'd1 : $unsigned(v);
	endfunction

	// signed value from sign and wide magnitude, saturated
	function automatic fx_t sat_from_mag(logic neg, wide_t m);
		if (m[127:63] != '0)
			return neg ? FX_MIN : FX_MAX;
		return neg ? fx_t'((~m[63:0]) + 64'd1) : fx_t'(m[63:0]);
	endfunction

	// sum of two sign-magnitude values
	function automatic sgnwide_t sgn_sum(logic na, wide_t ma, logic nb, wide_t mb);
		sgnwide_t r;
		if (na == nb) begin
			r.neg = na;
			r.m   = ma + mb;
		end else if (ma < mb) begin
			r.neg = nb;
			r.m   = mb - ma;
		end else begin
			r.neg = na;
			r.m   = ma - mb;
		end
		if (r.m == '0)
			r.neg = 1'b0;
		return r;
	endfunction

endpackage

FILE: design/newton_fractal_root_classifier.sv
// newton_fractal_root_classifier: top level, step sequencer, shared multiplier
// and divider ring of nfrc_div_cell instances
// depends on nfrc_pkg, nfrc_mul, nfrc_div_cell

// Classifies one pixel at a time: the start point row + column*i runs through
// iteration_count Newton steps for z^5 - z in saturating 40.24 fixed point and
// the item returns the nearest root code (1, -1, 0, i, -i as 1 to 5, else 0).
// One item is taken at a time; a step with a zero derivative skips the divisor
// products and the division. A full step sends 18 products through the one
// shared multiplier, runs the divisor normalize loop one bit at a time, and
// forms the two 128-bit quotients in the ring of eight divider cells, one
// quotient bit per cycle.
// A finished result sits in the output register while the next item runs.
module newton_fractal_root_classifier #(
	parameter int GRID_SIZE     = nfrc_pkg::DEF_GRID_SIZE,
	parameter int FRACTION_BITS = nfrc_pkg::DEF_FRACTION_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [$clog2(GRID_SIZE)-1:0]      row,
	input  logic [$clog2(GRID_SIZE)-1:0]      column,
	// result items
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [$clog2(GRID_SIZE)-1:0]      pixel_row,
	output logic [$clog2(GRID_SIZE)-1:0]      pixel_column,
	output logic [nfrc_pkg::CODE_W-1:0]       root_code,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [nfrc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int COORD_W = $clog2(GRID_SIZE);
	localparam int TOL_UP  = (FRACTION_BITS >= nfrc_pkg::TOL_FRACTION) ?
		FRACTION_BITS - nfrc_pkg::TOL_FRACTION : 0;
	localparam int TOL_DN  = (FRACTION_BITS >= nfrc_pkg::TOL_FRACTION) ?
		0 : nfrc_pkg::TOL_FRACTION - FRACTION_BITS;
	localparam int CNT_W   = $clog2(nfrc_pkg::DIV_STEPS);
	localparam nfrc_pkg::fx_t FX_ONE = 64'sd1 <<< FRACTION_BITS;
	localparam nfrc_pkg::fx_t ROOT_RE [nfrc_pkg::NUM_ROOTS] = '{FX_ONE, -FX_ONE, 0, 0, 0};
	localparam nfrc_pkg::fx_t ROOT_IM [nfrc_pkg::NUM_ROOTS] = '{0, 0, 0, FX_ONE, -FX_ONE};

	// complex product phases of one step
	localparam logic [1:0] PH_SQ    = 2'd0;
	localparam logic [1:0] PH_QUAD  = 2'd1;
	localparam logic [1:0] PH_FIFTH = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE, S_CM_MUL, S_CM_FIN, S_PREP_A, S_PREP_B, S_PREP_C, S_PREP_D,
		S_NORM_INIT, S_NORM, S_DM_MUL, S_DSUM, S_DSCALE, S_DIV, S_UPDATE,
		S_STEP_END, S_CLASS, S_OUT
	} state_t;

	state_t                         state_q;
	logic [1:0]                     ph_q;
	logic [2:0]                     j_q;
	logic                           start_q;
	logic                           start_d;
	logic [nfrc_pkg::ITER_W-1:0]    it_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           out_valid_q;
	logic [COORD_W-1:0]             pixel_row_q;
	logic [COORD_W-1:0]             pixel_column_q;
	logic [nfrc_pkg::CODE_W-1:0]    root_code_q;

	logic [nfrc_pkg::TOL_W-1:0]     tolerance_q;
	logic [nfrc_pkg::ITER_W-1:0]    iteration_count_q;

	nfrc_pkg::fx_t    zr_q, zi_q, wr_q, wi_q, vr_q, vi_q;
	nfrc_pkg::fx_t    t_q [4];
	nfrc_pkg::fx_t    pr_q, pi_q, dr_q, di_q, qr_q, qi_q;
	logic [63:0]      c_q, e_q, den_q;
	logic             nc_q, ne_q;
	logic [5:0]       k_q;
	nfrc_pkg::wide_t  tm_q [4];
	nfrc_pkg::sgnwide_t numr_q, numi_q;
	logic [COORD_W-1:0]          row_q, col_q;
	logic [nfrc_pkg::CODE_W-1:0] code_q;

	nfrc_pkg::fx_t    sa, sb, xr, xi, yr, yi;
	logic [63:0]      mul_a, mul_b, dm_a, dm_b;
	logic             mul_done;
	nfrc_pkg::wide_t  mul_prod;
	nfrc_pkg::fx_t    fx_res;
	logic             norm_more;
	logic [6:0]       k_ext;
	logic [6:0]       f_ext;
	nfrc_pkg::wide_t  mr, mi;
	logic [63:0]      tol_scaled;
	logic [nfrc_pkg::CODE_W-1:0] class_code;
	logic             div_load;
	nfrc_pkg::div_data_t div_init;
	nfrc_pkg::div_data_t ring [nfrc_pkg::DIV_CELLS];

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign pixel_row    = pixel_row_q;
	assign pixel_column = pixel_column_q;
	assign root_code    = root_code_q;
	assign cfg_ready    = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q       <= nfrc_pkg::TOL_W'(16777);
			iteration_count_q <= nfrc_pkg::ITER_W'(100);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				nfrc_pkg::CFG_TOLERANCE:  tolerance_q <= cfg_data[nfrc_pkg::TOL_W-1:0];
				nfrc_pkg::CFG_ITER_COUNT: iteration_count_q <= cfg_data[nfrc_pkg::ITER_W-1:0];
			endcase
		end
	end

	// multiplier operands: magnitudes of the signed complex factors, or divisor term magnitudes
	always_comb begin
		xr = (ph_q == PH_SQ) ? zr_q : wr_q;
		xi = (ph_q == PH_SQ) ? zi_q : wi_q;
		yr = (ph_q == PH_QUAD) ? wr_q : zr_q;
		yi = (ph_q == PH_QUAD) ? wi_q : zi_q;
		unique case (j_q[1:0])
			2'd0: begin sa = xr; sb = yr; end
			2'd1: begin sa = xi; sb = yi; end
			2'd2: begin sa = xr; sb = yi; end
			default: begin sa = xi; sb = yr; end
		endcase
		unique case (j_q)
			3'd0: begin dm_a = c_q; dm_b = c_q; end
			3'd1: begin dm_a = e_q; dm_b = e_q; end
			3'd2: begin dm_a = nfrc_pkg::mag64(pr_q); dm_b = c_q; end
			3'd3: begin dm_a = nfrc_pkg::mag64(pi_q); dm_b = e_q; end
			3'd4: begin dm_a = nfrc_pkg::mag64(pi_q); dm_b = c_q; end
			3'd5: begin dm_a = nfrc_pkg::mag64(pr_q); dm_b = e_q; end
			default: begin dm_a = c_q; dm_b = c_q; end
		endcase
		mul_a = (state_q == S_CM_MUL) ? nfrc_pkg::mag64(sa) : dm_a;
		mul_b = (state_q == S_CM_MUL) ? nfrc_pkg::mag64(sb) : dm_b;
	end

	nfrc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// fixed-point product, truncated toward zero and saturated
	assign fx_res = nfrc_pkg::sat_from_mag(sa[63] ^ sb[63], mul_prod >> FRACTION_BITS);

	// divisor still too wide for the 31-bit normalized form
	assign norm_more = (c_q[63:31] != '0) || (e_q[63:31] != '0);

	// numerators scaled by 2^(F - k)
	assign k_ext = {1'b0, k_q};
	assign f_ext = 7'(FRACTION_BITS);
	always_comb begin
		if (f_ext >= k_ext) begin
			mr = numr_q.m << (f_ext - k_ext);
			mi = numi_q.m << (f_ext - k_ext);
		end else begin
			mr = numr_q.m >> (k_ext - f_ext);
			mi = numi_q.m >> (k_ext - f_ext);
		end
		div_init.den    = den_q;
		div_init.re.rem = '0;
		div_init.re.nq  = mr;
		div_init.im.rem = '0;
		div_init.im.nq  = mi;
	end

	assign div_load = (state_q == S_DSCALE);

	// divider ring; the item circulates until all quotient bits are done
	for (genvar g = 0; g < nfrc_pkg::DIV_CELLS; g++) begin : g_div
		nfrc_pkg::div_data_t cell_in;
		if (g == 0) begin : g_head
			assign cell_in = div_load ? div_init : ring[nfrc_pkg::DIV_CELLS-1];
		end else begin : g_body
			assign cell_in = ring[g-1];
		end
		nfrc_div_cell u_cell (
			.clk   (clk),
			.d_in  (cell_in),
			.d_out (ring[g])
		);
	end

	// root match, the last matching root in checking order wins
	assign tol_scaled = (64'(tolerance_q) << TOL_UP) >> TOL_DN;
	always_comb begin
		class_code = nfrc_pkg::ROOT_NONE;
		for (int r = 0; r < nfrc_pkg::NUM_ROOTS; r++) begin
			if (nfrc_pkg::mag64(nfrc_pkg::sat_sub(zr_q, ROOT_RE[r])) < tol_scaled &&
					nfrc_pkg::mag64(nfrc_pkg::sat_sub(zi_q, ROOT_IM[r])) < tol_scaled)
				class_code = nfrc_pkg::CODE_W'(r + 1);
		end
	end

	// multiplier launch for the next product
	always_comb begin
		unique case (state_q)
			S_IDLE:     start_d = in_valid && (iteration_count_q != '0);
			S_CM_MUL:   start_d = mul_done && (j_q != 3'd3);
			S_CM_FIN:   start_d = (ph_q == PH_SQ) || (ph_q == PH_QUAD);
			S_NORM:     start_d = !norm_more;
			S_DM_MUL:   start_d = mul_done && (j_q != 3'd5);
			S_STEP_END: start_d = (9'(it_q) + 9'd1 < 9'(iteration_count_q));
			default:    start_d = 1'b0;
		endcase
	end

	// step sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= PH_SQ;
			j_q         <= '0;
			start_q     <= 1'b0;
			it_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= start_d;
			if (state_q == S_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						it_q <= '0;
						if (iteration_count_q == '0) begin
							state_q <= S_CLASS;
						end else begin
							state_q <= S_CM_MUL;
							ph_q    <= PH_SQ;
							j_q     <= '0;
						end
					end
				end
				S_CM_MUL: begin
					if (mul_done) begin
						if (j_q == 3'd3)
							state_q <= S_CM_FIN;
						else
							j_q <= j_q + 3'd1;
					end
				end
				S_CM_FIN: begin
					unique case (ph_q)
						PH_SQ: begin
							ph_q    <= PH_QUAD;
							j_q     <= '0;
							state_q <= S_CM_MUL;
						end
						PH_QUAD: begin
							ph_q    <= PH_FIFTH;
							j_q     <= '0;
							state_q <= S_CM_MUL;
						end
						default: state_q <= S_PREP_A;
					endcase
				end
				S_PREP_A:    state_q <= S_PREP_B;
				S_PREP_B:    state_q <= S_PREP_C;
				S_PREP_C:    state_q <= S_PREP_D;
				S_PREP_D:    state_q <= S_NORM_INIT;
				S_NORM_INIT: begin
					if (dr_q == '0 && di_q == '0)
						state_q <= S_STEP_END;
					else
						state_q <= S_NORM;
				end
				S_NORM: begin
					if (!norm_more) begin
						state_q <= S_DM_MUL;
						j_q     <= '0;
					end
				end
				S_DM_MUL: begin
					if (mul_done) begin
						if (j_q == 3'd5)
							state_q <= S_DSUM;
						else
							j_q <= j_q + 3'd1;
					end
				end
				S_DSUM:   state_q <= S_DSCALE;
				S_DSCALE: begin
					state_q <= S_DIV;
					cnt_q   <= '0;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(nfrc_pkg::DIV_STEPS - 1))
						state_q <= S_UPDATE;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_UPDATE: state_q <= S_STEP_END;
				S_STEP_END: begin
					if (9'(it_q) + 9'd1 >= 9'(iteration_count_q)) begin
						state_q <= S_CLASS;
					end else begin
						it_q    <= it_q + 1'b1;
						ph_q    <= PH_SQ;
						j_q     <= '0;
						state_q <= S_CM_MUL;
					end
				end
				S_CLASS: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						pixel_row_q    <= row_q;
						pixel_column_q <= col_q;
						root_code_q    <= code_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					zr_q  <= nfrc_pkg::fx_t'(64'(row) << FRACTION_BITS);
					zi_q  <= nfrc_pkg::fx_t'(64'(column) << FRACTION_BITS);
					row_q <= row;
					col_q <= column;
				end
			end
			S_CM_MUL: begin
				if (mul_done)
					t_q[j_q[1:0]] <= fx_res;
			end
			S_CM_FIN: begin
				if (ph_q == PH_FIFTH) begin
					vr_q <= nfrc_pkg::sat_sub(t_q[0], t_q[1]);
					vi_q <= nfrc_pkg::sat_add(t_q[2], t_q[3]);
				end else begin
					wr_q <= nfrc_pkg::sat_sub(t_q[0], t_q[1]);
					wi_q <= nfrc_pkg::sat_add(t_q[2], t_q[3]);
				end
			end
			// p = z^5 - z, p' = 5 z^4 - 1 built by doubling twice and adding
			S_PREP_A: begin
				pr_q <= nfrc_pkg::sat_sub(vr_q, zr_q);
				pi_q <= nfrc_pkg::sat_sub(vi_q, zi_q);
				dr_q <= nfrc_pkg::sat_add(wr_q, wr_q);
				di_q <= nfrc_pkg::sat_add(wi_q, wi_q);
			end
			S_PREP_B: begin
				dr_q <= nfrc_pkg::sat_add(dr_q, dr_q);
				di_q <= nfrc_pkg::sat_add(di_q, di_q);
			end
			S_PREP_C: begin
				dr_q <= nfrc_pkg::sat_add(dr_q, wr_q);
				di_q <= nfrc_pkg::sat_add(di_q, wi_q);
			end
			S_PREP_D: dr_q <= nfrc_pkg::sat_sub(dr_q, FX_ONE);
			S_NORM_INIT: begin
				c_q  <= nfrc_pkg::mag64(dr_q);
				e_q  <= nfrc_pkg::mag64(di_q);
				nc_q <= dr_q[63];
				ne_q <= di_q[63];
				k_q  <= '0;
			end
			// one bit of divisor normalization per cycle
			S_NORM: begin
				if (norm_more) begin
					c_q <= c_q >> 1;
					e_q <= e_q >> 1;
					k_q <= k_q + 6'd1;
				end
			end
			S_DM_MUL: begin
				if (mul_done) begin
					if (j_q == 3'd0)
						den_q <= mul_prod[63:0];
					else if (j_q == 3'd1)
						den_q <= den_q + mul_prod[63:0];
					else
						tm_q[2'(j_q - 3'd2)] <= mul_prod;
				end
			end
			// signed numerators of both quotient parts
			S_DSUM: begin
				numr_q <= nfrc_pkg::sgn_sum(
					(tm_q[0] != '0) && (pr_q[63] != nc_q), tm_q[0],
					(tm_q[1] != '0) && (pi_q[63] != ne_q), tm_q[1]);
				numi_q <= nfrc_pkg::sgn_sum(
					(tm_q[2] != '0) && (pi_q[63] != nc_q), tm_q[2],
					(tm_q[3] != '0) && (pr_q[63] == ne_q), tm_q[3]);
			end
			S_DIV: begin
				if (cnt_q == CNT_W'(nfrc_pkg::DIV_STEPS - 1)) begin
					qr_q <= nfrc_pkg::sat_from_mag(numr_q.neg,
						ring[nfrc_pkg::DIV_CELLS-1].re.nq);
					qi_q <= nfrc_pkg::sat_from_mag(numi_q.neg,
						ring[nfrc_pkg::DIV_CELLS-1].im.nq);
				end
			end
			S_UPDATE: begin
				zr_q <= nfrc_pkg::sat_sub(zr_q, qr_q);
				zi_q <= nfrc_pkg::sat_sub(zi_q, qi_q);
			end
			S_CLASS: code_q <= class_code;
			default: begin
			end
		endcase
	end

	// an accepted item always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != S_IDLE))
		else $error("accepted item did not start");

	// multiplier results arrive only while a product is awaited
	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_CM_MUL || state_q == S_DM_MUL))
		else $error("unexpected multiplier result");

	// a result appears only from the output state
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("result raised outside output state");

	// result code stays within the root codes
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (root_code_q <= nfrc_pkg::CODE_W'(nfrc_pkg::NUM_ROOTS)))
		else $error("root code out of range");

endmodule

FILE: design/nfrc_mul.sv
// nfrc_mul: 64 x 64 unsigned multiplier built from four 32 x 32 partial
// products over consecutive cycles, accumulated into a 128-bit product
// depends on nfrc_pkg
module nfrc_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [63:0]         a,
	input  logic [63:0]         b,
	output logic                done,
	output nfrc_pkg::wide_t     prod
);

	logic [63:0]     a_q;
	logic [63:0]     b_q;
	logic [2:0]      idx_q;
	logic            busy_q;
	logic            done_q;
	logic            pp_vld_s1;
	logic [1:0]      pp_idx_s1;
	logic [63:0]     pp_s1;
	nfrc_pkg::wide_t acc_q;
	logic [31:0]     a_half;
	logic [31:0]     b_half;
	logic [6:0]      pp_shift;

	// operand halves for the current partial product
	assign a_half   = idx_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_half   = idx_q[0] ? b_q[63:32] : b_q[31:0];
	// weight of the registered partial product: 0, 32, 32 or 64
	assign pp_shift = {pp_idx_s1[1] & pp_idx_s1[0], pp_idx_s1[1] ^ pp_idx_s1[0], 5'b0};

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			idx_q     <= '0;
			pp_vld_s1 <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (idx_q == 3'd4);
			if (start) begin
				busy_q    <= 1'b1;
				idx_q     <= '0;
				pp_vld_s1 <= 1'b0;
			end else if (busy_q) begin
				if (idx_q == 3'd4) begin
					busy_q    <= 1'b0;
					pp_vld_s1 <= 1'b0;
				end else begin
					pp_vld_s1 <= 1'b1;
				end
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// operand capture, partial product and accumulation
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else begin
			if (busy_q && idx_q != 3'd4) begin
				pp_s1     <= a_half * b_half;
				pp_idx_s1 <= idx_q[1:0];
			end
			if (pp_vld_s1)
				acc_q <= acc_q + (nfrc_pkg::wide_t'(pp_s1) << pp_shift);
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

FILE: design/nfrc_div_cell.sv
// nfrc_div_cell: one restoring division step for two quotient lanes that
// share a divisor, registered toward the next cell of the ring
// depends on nfrc_pkg
module nfrc_div_cell (
	input  logic                clk,
	input  nfrc_pkg::div_data_t d_in,
	output nfrc_pkg::div_data_t d_out
);

	nfrc_pkg::div_data_t cell_q;
	nfrc_pkg::div_data_t nxt;

	// shift in the next numerator bit, subtract the divisor when it fits
	function automatic nfrc_pkg::div_lane_t lane_step(nfrc_pkg::div_lane_t l,
			logic [63:0] den);
		nfrc_pkg::div_lane_t r;
		logic [63:0]         sh;
		logic [64:0]         diff;
		logic                fits;
		sh   = {l.rem[62:0], l.nq[127]};
		diff = {1'b0, sh} - {1'b0, den};
		fits = !diff[64];
		r.rem = fits ? diff[63:0] : sh;
		r.nq  = {l.nq[126:0], fits};
		return r;
	endfunction

	// step both lanes
	always_comb begin
		nxt.den = d_in.den;
		nxt.re  = lane_step(d_in.re, d_in.den);
		nxt.im  = lane_step(d_in.im, d_in.den);
	end

	always_ff @(posedge clk) begin
		cell_q <= nxt;
	end

	assign d_out = cell_q;

endmodule
